/* hw/rtl/fud_pkg.sv */
package fud_pkg;

    localparam int MAX_RESULTS = 4;
    localparam int RES_IDX_W   = $clog2(MAX_RESULTS);
    localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);
    localparam int QUEUE_DEPTH = 2;

    // register map
    localparam logic REG_DELIM_MODE = 1'b0;
    localparam logic REG_MAX_PAIRS  = 1'b1;

    localparam logic       DELIM_MODE_RST = 1'b0;
    localparam logic [9:0] MAX_PAIRS_RST  = 10'd1000;

    localparam logic MODE_BODY  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

    localparam logic [1:0] ESC_IDLE  = 2'd0;
    localparam logic [1:0] ESC_PCT   = 2'd1;
    localparam logic [1:0] ESC_DIGIT = 2'd2;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_input;
    } t_in_item;

    typedef struct packed {
        logic       out_kind;
        logic [7:0] out_byte;
        logic       in_value_part;
        logic       pair_kept;
        logic       last_of_run;
    } t_out_item;

    typedef struct packed {
        logic       delimiter_mode;
        logic [9:0] max_pairs;
    } t_cfg;

    typedef struct packed {
        logic       kind;
        logic [7:0] data;
        logic       value_part;
        logic       kept;
    } t_result;

    // all results caused by one input item
    typedef struct packed {
        logic [RES_CNT_W-1:0]            count;
        t_result [MAX_RESULTS-1:0]       res;
    } t_bundle;

    // {is hex, nibble}
    function automatic logic [4:0] hex_decode(logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, c[3:0]};
        end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

    function automatic t_bundle put(t_bundle b, logic kind, logic [7:0] d, logic vp,
                                    logic kp);
        t_bundle o;
        o = b;
        if (b.count < RES_CNT_W'(MAX_RESULTS)) begin
            o.res[b.count[RES_IDX_W-1:0]] = '{kind: kind, data: d, value_part: vp, kept: kp};
            o.count = b.count + RES_CNT_W'(1);
        end
        return o;
    endfunction

endpackage

/* hw/rtl/fud_front.sv */
module fud_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  fud_pkg::t_cfg     i_cfg,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  fud_pkg::t_in_item i_in_item,
    input  logic              i_q_full,
    output logic              o_push,
    output fud_pkg::t_bundle  o_bundle
);
    import fud_pkg::*;

    logic [1:0] r_esc, n_esc;
    logic [7:0] r_held, n_held;
    logic       r_seq, n_seq;
    logic       r_phb, n_phb;
    logic [9:0] r_cnt, n_cnt;
    logic       r_lim, n_lim;
    t_bundle    b;
    logic       accept;

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && o_in_ready;
    assign o_push     = accept && (b.count != '0);
    assign o_bundle   = b;

    always_comb begin
        logic [7:0] c;
        logic [4:0] hc;
        logic [4:0] hh;
        logic       done;
        logic       delim;
        n_esc  = r_esc;
        n_held = r_held;
        n_seq  = r_seq;
        n_phb  = r_phb;
        n_cnt  = r_cnt;
        n_lim  = r_lim;
        b      = '0;
        c      = i_in_item.in_byte;
        hc     = hex_decode(c);
        hh     = hex_decode(r_held);
        done   = 1'b0;
        delim  = 1'b0;
        if (!r_lim) begin
            if (!(i_cfg.delimiter_mode == MODE_BODY && c == CH_CR)) begin
                unique case (n_esc)
                    ESC_PCT: begin
                        if (hc[4]) begin
                            n_held = c;
                            n_esc  = ESC_DIGIT;
                            done   = 1'b1;
                        end else begin
                            b     = put(b, KIND_DATA, CH_PCT, n_seq, 1'b0);
                            n_esc = ESC_IDLE;
                        end
                    end
                    ESC_DIGIT: begin
                        if (hc[4]) begin
                            b     = put(b, KIND_DATA, {hh[3:0], hc[3:0]}, n_seq, 1'b0);
                            n_esc = ESC_IDLE;
                            done  = 1'b1;
                        end else begin
                            b     = put(b, KIND_DATA, CH_PCT, n_seq, 1'b0);
                            b     = put(b, KIND_DATA, n_held, n_seq, 1'b0);
                            n_esc = ESC_IDLE;
                        end
                    end
                    default: n_esc = ESC_IDLE;
                endcase
                if (!done) begin
                    if (i_cfg.delimiter_mode == MODE_QUERY) begin
                        delim = (c == CH_AMP) || (c == CH_SEMI);
                    end else begin
                        delim = (c == CH_AMP) || (c == CH_LF);
                    end
                    if (delim) begin
                        if (n_phb) begin
                            b = put(b, KIND_END, 8'd0, 1'b0, n_seq);
                            if (n_seq) begin
                                n_cnt = n_cnt + 10'd1;
                                if (n_cnt >= i_cfg.max_pairs) begin
                                    n_lim = 1'b1;
                                end
                            end
                        end
                        n_seq = 1'b0;
                        n_phb = 1'b0;
                    end else begin
                        n_phb = 1'b1;
                        if (c == CH_PCT) begin
                            n_esc = ESC_PCT;
                        end else if (c == CH_EQ && !n_seq) begin
                            n_seq = 1'b1;
                        end else begin
                            b = put(b, KIND_DATA, (c == CH_PLUS) ? CH_SPACE : c, n_seq, 1'b0);
                        end
                    end
                end
            end
            // end of stream: flush pending escape, close open pair
            if (i_in_item.end_of_input && !n_lim) begin
                if (n_esc == ESC_PCT) begin
                    b = put(b, KIND_DATA, CH_PCT, n_seq, 1'b0);
                end else if (n_esc == ESC_DIGIT) begin
                    b = put(b, KIND_DATA, CH_PCT, n_seq, 1'b0);
                    b = put(b, KIND_DATA, n_held, n_seq, 1'b0);
                end
                n_esc = ESC_IDLE;
                if (n_phb) begin
                    b = put(b, KIND_END, 8'd0, 1'b0, n_seq);
                    if (n_seq) begin
                        n_cnt = n_cnt + 10'd1;
                        if (n_cnt >= i_cfg.max_pairs) begin
                            n_lim = 1'b1;
                        end
                    end
                end
                n_seq = 1'b0;
                n_phb = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esc <= ESC_IDLE;
            r_seq <= 1'b0;
            r_phb <= 1'b0;
            r_cnt <= '0;
            r_lim <= 1'b0;
        end else if (accept) begin
            r_esc <= n_esc;
            r_seq <= n_seq;
            r_phb <= n_phb;
            r_cnt <= n_cnt;
            r_lim <= n_lim;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_held <= n_held;
        end
    end

`ifndef SYNTH
    // once the limit is hit nothing more is produced
    a_lim_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lim |-> !o_push)
        else $error("push after pair limit");
    // limit stays set until reset
    a_lim_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lim |=> r_lim)
        else $error("pair limit cleared");
    // state only moves on an accepted item
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !accept |=> $stable(r_cnt) && $stable(r_esc))
        else $error("front state changed without item");
`endif
endmodule

/* hw/rtl/fud_queue.sv */
module fud_queue #(
    parameter int DEPTH = fud_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  fud_pkg::t_bundle i_data,
    output logic             o_full,
    output logic             o_empty,
    input  logic             i_pop,
    output fud_pkg::t_bundle o_head
);
    import fud_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_bundle            r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr, r_rd;
    logic [CNT_W-1:0]   r_cnt;
    logic               do_push, do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            unique case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + CNT_W'(1);
                2'b01:   r_cnt <= r_cnt - CNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

`ifndef SYNTH
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(DEPTH))
        else $error("queue overfilled");
    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_push && !do_pop) |=> r_cnt == $past(r_cnt) + CNT_W'(1))
        else $error("queue count lost a push");
    a_no_empty_bundle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> o_head.count != '0)
        else $error("empty bundle queued");
`endif
endmodule

/* hw/rtl/fud_back.sv */
module fud_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_empty,
    input  fud_pkg::t_bundle   i_head,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output fud_pkg::t_out_item o_out_item
);
    import fud_pkg::*;

    logic [RES_IDX_W-1:0] r_idx;
    t_result              cur;
    logic                 last;
    logic                 take;

    assign o_out_valid = !i_empty;
    assign take        = o_out_valid && i_out_ready;
    assign cur         = i_head.res[r_idx];
    assign last        = ({1'b0, r_idx} == i_head.count - RES_CNT_W'(1));
    assign o_pop       = take && last;

    assign o_out_item = '{out_kind:      cur.kind,
                          out_byte:      cur.data,
                          in_value_part: cur.value_part,
                          pair_kept:     cur.kept,
                          last_of_run:   last};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (take) begin
            r_idx <= last ? '0 : r_idx + RES_IDX_W'(1);
        end
    end

`ifndef SYNTH
    a_idx_in_bundle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> {1'b0, r_idx} < i_head.count)
        else $error("result index past bundle");
    a_idx_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_idx == '0)
        else $error("index not restarted after bundle");
    a_marker_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.out_kind == KIND_END) |->
            (o_out_item.out_byte == 8'd0 && !o_out_item.in_value_part))
        else $error("marker carries data");
`endif
endmodule

/* hw/rtl/form_urlencoded_decoder_top.sv */
// the first result of an item is offered from the queue once the bundles ahead of it are handed out
// throughput: one item per cycle while items give at most one result each and the output is ready
// an item giving several results holds the output side until all are taken; with items following
// back to back the two-entry queue fills and the input side stalls
// an item giving no result is accepted and produces nothing downstream
// reset: synchronous active-low, clears parse state, pair count, queue; registers to defaults
module form_urlencoded_decoder_top #(
    parameter int QUEUE_DEPTH = fud_pkg::QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input bytes
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  fud_pkg::t_in_item  i_in_item,
    // decoded results
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output fud_pkg::t_out_item o_out_item,
    // register port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import fud_pkg::*;

    t_cfg    r_cfg;
    logic    q_full, q_empty, q_pop, f_push;
    t_bundle f_bundle, q_head;
    logic    reg_wr;
    logic    reg_sel;

    // register file: one write per access phase, pready tied high
    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign reg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.delimiter_mode <= DELIM_MODE_RST;
            r_cfg.max_pairs      <= MAX_PAIRS_RST;
        end else if (reg_wr) begin
            unique case (reg_sel)
                REG_DELIM_MODE: r_cfg.delimiter_mode <= pwdata[0];
                REG_MAX_PAIRS:  r_cfg.max_pairs      <= pwdata[9:0];
                default:        r_cfg                <= r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_DELIM_MODE: prdata = {31'd0, r_cfg.delimiter_mode};
            REG_MAX_PAIRS:  prdata = {22'd0, r_cfg.max_pairs};
            default:        prdata = '0;
        endcase
    end

    // front: takes a byte every cycle while the queue is not full, runs the escape and pair state, builds a bundle
    fud_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .i_q_full   (q_full),
        .o_push     (f_push),
        .o_bundle   (f_bundle)
    );

    // queue of bundles so a stalled consumer does not stop the front at once
    fud_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  (f_bundle),
        .o_full  (q_full),
        .o_empty (q_empty),
        .i_pop   (q_pop),
        .o_head  (q_head)
    );

    // back: hands out the results of the head bundle one item per cycle while the consumer is ready
    fud_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (q_empty),
        .i_head      (q_head),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

`ifndef SYNTH
    // a full queue must hold the input side off
    a_full_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_full |-> !o_in_ready)
        else $error("input taken with queue full");
    // results only flow when something has been queued
    a_valid_needs_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !q_empty)
        else $error("output valid with empty queue");
    // register write lands the next cycle
    a_cfg_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (reg_wr && reg_sel == REG_MAX_PAIRS) |=> r_cfg.max_pairs == $past(pwdata[9:0]))
        else $error("max_pairs write lost");
`endif
endmodule
